// ===== hdl/wzt_pkg.sv =====
// ----------------------------------------------------------------------------
// wzt_pkg: shared types and constants for the window depth-order table
// Slot count, style and operation codes, status codes, scan unit modes.
// ----------------------------------------------------------------------------
package wzt_pkg;

  localparam int unsigned Slots     = 16;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned IdW       = $clog2(Slots + 1);
  localparam logic [IdW-1:0] WinidUnused = IdW'(Slots);
  localparam logic [15:0] DepthMax  = 16'hFFFF;

  localparam logic [1:0] WinStylePopup   = 2'd1;
  localparam logic [1:0] WinStyleDesktop = 2'd2;

  localparam logic [2:0] OpCreate  = 3'd0;
  localparam logic [2:0] OpDestroy = 3'd1;
  localparam logic [2:0] OpDestOwn = 3'd2;
  localparam logic [2:0] OpActive  = 3'd3;
  localparam logic [2:0] OpHit     = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFree = 2'd1;
  localparam logic [1:0] StNoWin  = 2'd2;

  // scan unit modes
  localparam logic [1:0] ScanTop  = 2'd0;
  localparam logic [1:0] ScanHit  = 2'd2;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] depth;
    logic [15:0] owner;
    logic [1:0]  style;
  } win_t;

endpackage

// ===== hdl/wzt_scan.sv =====
// ----------------------------------------------------------------------------
// wzt_scan: shared per-slot compare unit
// Evaluates one slot per cycle while step_i is high: best-depth tracking, with a window match in hit-test mode.
// ----------------------------------------------------------------------------
module wzt_scan (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    step_i,
  input  logic [1:0]              mode_i,
  input  logic [wzt_pkg::SlotW-1:0] idx_i,
  input  logic                    used_i,
  input  wzt_pkg::win_t           win_i,
  input  logic [15:0]             px_i,
  input  logic [15:0]             py_i,
  output logic                    found_o,
  output logic [wzt_pkg::SlotW-1:0] best_o,
  output logic [15:0]             best_z_o
);

  logic found_q, found_d;
  logic [wzt_pkg::SlotW-1:0] best_q, best_d;
  logic [15:0] bz_q, bz_d;
  logic signed [17:0] px, py, l, t, r, b;
  logic in_win, cand;

  always_comb begin
    px = 18'(signed'(px_i));
    py = 18'(signed'(py_i));
    l  = 18'(signed'(win_i.left));
    t  = 18'(signed'(win_i.top));
    // right and bottom edges need a bit beyond the signed 16-bit range
    r  = l + 18'(signed'({1'b0, win_i.width}));
    b  = t + 18'(signed'({1'b0, win_i.height}));
    in_win = (px >= l) && (px < r) && (py >= t) && (py < b);
    cand = used_i && (mode_i != wzt_pkg::ScanHit || in_win) &&
           (!found_q || win_i.depth > bz_q);
    found_d = found_q;
    best_d  = best_q;
    bz_d    = bz_q;
    if (clear_i) begin
      found_d = 1'b0;
      best_d  = '0;
      bz_d    = '0;
    end else if (step_i && cand) begin
      found_d = 1'b1;
      best_d  = idx_i;
      bz_d    = win_i.depth;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bz_q   <= bz_d;
  end

  assign found_o  = found_q;
  assign best_o   = best_q;
  assign best_z_o = bz_q;

endmodule

// ===== hdl/window_zorder_table.sv =====
// ----------------------------------------------------------------------------
// window_zorder_table: slot table with depth order, activation and hit test
//
//  channel | valid    | ready    | payload
//  in      | valid_i  | ready_o  | operation_i slot_i pos_x_i pos_y_i size_w_i
//          |          |          | size_h_i owner_id_i style_code_i
//  out     | valid_o  | ready_i  | status_o result_slot_o active_now_o
//          |          |          | active_before_o active_changed_o
//
// One slot is visited per cycle by a shared compare unit. Create, hit test
// and activate each walk every slot; a bad target or an unknown operation
// answers at once. Destroy frees the slot and, when it was the active or top
// window, rescans every slot and reactivates the deepest window found. Destroy
// by owner walks the slots and destroys each match in the same way. Reset
// clears the used bits at once; the block then takes items immediately.
// ready_o is low from accept until the result is taken.
// ----------------------------------------------------------------------------
module window_zorder_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  slot_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] size_w_i,
  input  logic [15:0] size_h_i,
  input  logic [15:0] owner_id_i,
  input  logic [1:0]  style_code_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic [4:0]  active_now_o,
  output logic [4:0]  active_before_o,
  output logic        active_changed_o
);

  localparam int unsigned SW = wzt_pkg::SlotW;
  localparam int unsigned IW = wzt_pkg::IdW;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SFree   = 4'd1;  // create: clear scan unit, then top scan
  localparam logic [3:0] STop    = 4'd2;  // top scan for create
  localparam logic [3:0] SWrite  = 4'd3;
  localparam logic [3:0] SReTop  = 4'd4;  // top scan after a destroy
  localparam logic [3:0] SActA   = 4'd5;  // activate: lower pass
  localparam logic [3:0] SActB   = 4'd6;  // activate: commit target
  localparam logic [3:0] SOwner  = 4'd7;  // owner walk
  localparam logic [3:0] SHit    = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;
  localparam logic [3:0] SKill   = 4'd10; // free one slot, decide reactivation
  localparam logic [3:0] SHitEnd = 4'd11;
  localparam logic [3:0] SReEnd  = 4'd12; // pick reactivation target

  logic [3:0] st_q;

  logic [wzt_pkg::Slots-1:0] used_q;
  wzt_pkg::win_t tab_q [wzt_pkg::Slots];

  logic [IW-1:0] active_q, top_q, before_q;
  logic [2:0]  op_q;
  logic [SW-1:0] tgt_q, free_q, own_q, free_idx;
  logic [15:0] px_q, py_q, w_q, h_q, owner_q, maxz_q, curz_q;
  logic [1:0]  style_q, status_q;
  logic [SW-1:0] rslot_q;
  logic        any_q, free_ok_q;
  logic [IW-1:0] idx_q;   // walk counter, holds Slots at end

  logic        sc_clear, sc_step, sc_found;
  logic [1:0]  sc_mode;
  logic [SW-1:0] sc_best, idx;
  logic [15:0] sc_bz;
  logic        walk_end;

  // owner walk: own_q is the next slot to test, own_done_q marks end of walk
  logic owner_hit, own_last, own_done_q;

  assign idx      = idx_q[SW-1:0];
  assign walk_end = (idx_q == IW'(wzt_pkg::Slots - 1));

  assign owner_hit = !own_done_q && used_q[own_q] && tab_q[own_q].owner == owner_q;
  assign own_last  = own_done_q || (own_q == SW'(wzt_pkg::Slots - 1));

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = wzt_pkg::Slots - 1; i >= 0; i--)
      if (!used_q[i]) free_idx = SW'(i);
  end

  wzt_scan u_scan (
    .clk_i, .rst_ni,
    .clear_i (sc_clear),
    .step_i  (sc_step),
    .mode_i  (sc_mode),
    .idx_i   (idx),
    .used_i  (used_q[idx]),
    .win_i   (tab_q[idx]),
    .px_i    (px_q),
    .py_i    (py_q),
    .found_o (sc_found),
    .best_o  (sc_best),
    .best_z_o(sc_bz)
  );

  always_comb begin
    sc_clear = (st_q == SIdle) || (st_q == SKill) || (st_q == SFree);
    sc_step  = (st_q == STop) || (st_q == SReTop) || (st_q == SHit);
    sc_mode  = (st_q == SHit) ? wzt_pkg::ScanHit : wzt_pkg::ScanTop;
  end

  assign ready_o = (st_q == SIdle);
  assign valid_o = (st_q == SDone);
  assign status_o        = status_q;
  assign result_slot_o   = (status_q != wzt_pkg::StOk) ? 4'd0 : 4'(rslot_q);
  assign active_now_o    = 5'(active_q);
  assign active_before_o = 5'(before_q);
  assign active_changed_o = (active_q != before_q);

  // activate target tgt_q starts in SActA with curz_q holding its depth, maxz_q cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      used_q   <= '0;
      active_q <= wzt_pkg::WinidUnused;
      top_q    <= wzt_pkg::WinidUnused;
      before_q <= wzt_pkg::WinidUnused;
      status_q <= wzt_pkg::StOk;
      idx_q    <= '0;
    end else begin
      case (st_q)
        SIdle: if (valid_i) begin
          before_q <= active_q;
          idx_q    <= '0;
          status_q <= (operation_i inside {wzt_pkg::OpDestroy, wzt_pkg::OpActive} &&
                       !used_q[slot_i[SW-1:0]]) ? wzt_pkg::StNoWin : wzt_pkg::StOk;
          case (operation_i)
            wzt_pkg::OpCreate:  st_q <= SFree;
            wzt_pkg::OpDestroy: st_q <= used_q[slot_i[SW-1:0]] ? SKill : SDone;
            wzt_pkg::OpActive:  st_q <= used_q[slot_i[SW-1:0]] ? SActA : SDone;
            wzt_pkg::OpDestOwn: st_q <= SOwner;
            wzt_pkg::OpHit:     st_q <= SHit;
            default:            st_q <= SDone;
          endcase
        end
        SFree: st_q <= STop;
        STop: begin
          idx_q <= idx_q + IW'(1);
          if (walk_end) st_q <= SWrite;
        end
        SWrite: begin
          if (!free_ok_q) status_q <= wzt_pkg::StNoFree;
          else used_q[free_q] <= 1'b1;
          st_q <= SDone;
        end
        SKill: begin
          used_q[tgt_q] <= 1'b0;
          idx_q <= '0;
          if (active_q == IW'(tgt_q) || top_q == IW'(tgt_q)) st_q <= SReTop;
          else st_q <= (op_q == wzt_pkg::OpDestOwn) ? SOwner : SDone;
        end
        SReTop: begin
          idx_q <= idx_q + IW'(1);
          if (walk_end) st_q <= SReEnd;
        end
        SReEnd: begin
          idx_q <= '0;
          if (sc_found) st_q <= SActA;
          else st_q <= (op_q == wzt_pkg::OpDestOwn) ? SOwner : SDone;
        end
        SActA: begin
          idx_q <= idx_q + IW'(1);
          if (walk_end) st_q <= SActB;
        end
        SActB: begin
          if (active_q != IW'(tgt_q)) begin
            active_q <= IW'(tgt_q);
            if (tab_q[tgt_q].style != wzt_pkg::WinStyleDesktop) top_q <= IW'(tgt_q);
          end
          st_q <= (op_q == wzt_pkg::OpDestOwn) ? SOwner : SDone;
        end
        SOwner: begin
          if (owner_hit) st_q <= SKill;
          else if (own_last) begin
            st_q <= SDone;
            if (!any_q) status_q <= wzt_pkg::StNoWin;
          end
        end
        SHit: begin
          idx_q <= idx_q + IW'(1);
          if (walk_end) st_q <= SHitEnd;
        end
        SHitEnd: begin
          if (!sc_found) status_q <= wzt_pkg::StNoWin;
          st_q <= SDone;
        end
        SDone: if (ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: if (valid_i) begin
        op_q <= operation_i; tgt_q <= slot_i[SW-1:0];
        px_q <= pos_x_i; py_q <= pos_y_i; w_q <= size_w_i; h_q <= size_h_i;
        owner_q <= owner_id_i; style_q <= style_code_i;
        rslot_q <= '0; any_q <= 1'b0; own_q <= '0; own_done_q <= 1'b0;
        maxz_q <= '0; curz_q <= tab_q[slot_i[SW-1:0]].depth;
        free_ok_q <= ~&used_q;
        free_q <= free_idx;
      end
      SWrite: if (free_ok_q) begin
        tab_q[free_q] <= '{left: px_q, top: py_q, width: w_q, height: h_q,
          owner: owner_q, style: style_q,
          depth: (style_q == wzt_pkg::WinStyleDesktop) ? 16'd0 :
                 !sc_found ? 16'd1 :
                 (sc_bz == wzt_pkg::DepthMax) ? wzt_pkg::DepthMax : sc_bz + 16'd1};
        rslot_q <= free_q;
      end
      SReEnd: if (sc_found) begin
        tgt_q <= sc_best; maxz_q <= '0; curz_q <= sc_bz;
      end
      SActA: if (tab_q[tgt_q].style != wzt_pkg::WinStyleDesktop && used_q[idx] &&
                 tab_q[idx].depth > curz_q && tab_q[idx].style != wzt_pkg::WinStylePopup) begin
        if (tab_q[idx].depth > maxz_q) maxz_q <= tab_q[idx].depth;
        tab_q[idx].depth <= tab_q[idx].depth - 16'd1;
      end
      SActB: if (tab_q[tgt_q].style != wzt_pkg::WinStyleDesktop && maxz_q != 16'd0)
        tab_q[tgt_q].depth <= maxz_q;
      SOwner: begin
        if (owner_hit) begin tgt_q <= own_q; any_q <= 1'b1; end
        if (own_q == SW'(wzt_pkg::Slots - 1)) own_done_q <= 1'b1;
        else own_q <= own_q + SW'(1);
      end
      SHitEnd: rslot_q <= sc_best;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !ready_o) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle && st_q != SDone) |-> !valid_o) else $error("early result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == wzt_pkg::StNoFree |-> &used_q) else $error("bad full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= wzt_pkg::WinidUnused) else $error("active out of range");

endmodule

// ===== tb/window_zorder_table_tb.sv =====
// ----------------------------------------------------------------------------
// window_zorder_table_tb: self-checking bench for the window depth-order table
// Drives create, destroy, destroy-by-owner, activate, hit-test and unknown-code items with
// random idling on both channels. A behavioral copy of the slot table
// predicts each result, and a scoreboard compares the results in order.
// ----------------------------------------------------------------------------
module window_zorder_table_tb;

  localparam int unsigned SlotCnt   = wzt_pkg::Slots;
  localparam int unsigned OpIgnored = 5;
  localparam logic [2:0]  OpTopCode = 3'd7;
  localparam int unsigned CycleCap  = 1500000;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] rslot;
    logic [4:0] act_now;
    logic [4:0] act_prev;
    logic       act_chg;
  } wres_t;

  // Scoreboard: behavioral copy of the slot table plus the queue of results
  // still owed by the block.
  class zorder_scoreboard;
    bit          used_q[SlotCnt];
    logic [15:0] left_q[SlotCnt];
    logic [15:0] topv_q[SlotCnt];
    logic [15:0] wid_q[SlotCnt];
    logic [15:0] hgt_q[SlotCnt];
    logic [15:0] dep_q[SlotCnt];
    logic [15:0] own_q[SlotCnt];
    logic [1:0]  sty_q[SlotCnt];
    int unsigned act_slot;
    int unsigned top_win;
    wres_t       owed_q[$];
    int unsigned mism;

    function new();
      for (int i = 0; i < SlotCnt; i++) begin
        used_q[i] = 0; left_q[i] = '0; topv_q[i] = '0; wid_q[i] = '0;
        hgt_q[i] = '0; dep_q[i] = '0; own_q[i] = '0; sty_q[i] = '0;
      end
      act_slot = SlotCnt;
      top_win  = SlotCnt;
      mism     = 0;
    endfunction

    function int unsigned deepest();
      int unsigned best;
      best = SlotCnt;
      for (int i = 0; i < SlotCnt; i++)
        if (used_q[i] && (best == SlotCnt || dep_q[i] > dep_q[best])) best = i;
      return best;
    endfunction

    function void raise_win(int unsigned id);
      logic [15:0] curz;
      logic [15:0] maxz;
      if (sty_q[id] != wzt_pkg::WinStyleDesktop) begin
        curz = dep_q[id];
        maxz = '0;
        for (int i = 0; i < SlotCnt; i++)
          if (used_q[i] && dep_q[i] > curz && sty_q[i] != wzt_pkg::WinStylePopup) begin
            if (dep_q[i] > maxz) maxz = dep_q[i];
            dep_q[i] = dep_q[i] - 16'd1;
          end
        if (maxz > 0) dep_q[id] = maxz;
      end
      if (id != act_slot) begin
        act_slot = id;
        if (sty_q[id] != wzt_pkg::WinStyleDesktop) top_win = id;
      end
    endfunction

    function void free_win(int unsigned id);
      int unsigned t;
      used_q[id] = 0;
      if (act_slot == id || top_win == id) begin
        t = deepest();
        if (t < SlotCnt) raise_win(t);
      end
    endfunction

    function void note_item(logic [2:0] op, logic [3:0] sl, logic [15:0] px,
                            logic [15:0] py, logic [15:0] w, logic [15:0] h,
                            logic [15:0] own, logic [1:0] sty);
      wres_t       r;
      int unsigned prev, f, t, hit;
      logic [15:0] z;
      bit          any;
      int          l, tp;
      prev = act_slot;
      r = '0;
      case (op)
        wzt_pkg::OpCreate: begin
          f = SlotCnt;
          for (int i = SlotCnt - 1; i >= 0; i--) if (!used_q[i]) f = i;
          if (f == SlotCnt) r.status = wzt_pkg::StNoFree;
          else begin
            if (sty == wzt_pkg::WinStyleDesktop) z = '0;
            else begin
              t = deepest();
              if (t < SlotCnt)
                z = (dep_q[t] == wzt_pkg::DepthMax) ? wzt_pkg::DepthMax : dep_q[t] + 16'd1;
              else z = 16'd1;
            end
            used_q[f] = 1; left_q[f] = px; topv_q[f] = py; wid_q[f] = w;
            hgt_q[f] = h; own_q[f] = own; sty_q[f] = sty; dep_q[f] = z;
            r.rslot = 4'(f);
          end
        end
        wzt_pkg::OpDestroy, wzt_pkg::OpActive: begin
          if (!used_q[sl]) r.status = wzt_pkg::StNoWin;
          else if (op == wzt_pkg::OpDestroy) free_win(sl);
          else raise_win(sl);
        end
        wzt_pkg::OpDestOwn: begin
          any = 0;
          for (int i = 0; i < SlotCnt; i++)
            if (used_q[i] && own_q[i] == own) begin
              free_win(i);
              any = 1;
            end
          if (!any) r.status = wzt_pkg::StNoWin;
        end
        wzt_pkg::OpHit: begin
          hit = SlotCnt;
          for (int i = 0; i < SlotCnt; i++) begin
            l  = $signed(left_q[i]);
            tp = $signed(topv_q[i]);
            if (used_q[i] && $signed(px) >= l && $signed(px) < l + int'(wid_q[i]) &&
                $signed(py) >= tp && $signed(py) < tp + int'(hgt_q[i]) &&
                (hit == SlotCnt || dep_q[i] > dep_q[hit])) hit = i;
          end
          if (hit == SlotCnt) r.status = wzt_pkg::StNoWin;
          else r.rslot = 4'(hit);
        end
        default: ;
      endcase
      if (r.status != wzt_pkg::StOk) r.rslot = '0;
      r.act_now  = 5'(act_slot);
      r.act_prev = 5'(prev);
      r.act_chg  = (act_slot != prev);
      owed_q.push_back(r);
    endfunction

    function void check_result(wres_t got);
      wres_t exp_r;
      if (owed_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = owed_q.pop_front();
      if (got !== exp_r) begin
        mism++;
        if (mism <= 10) begin
          $display("mismatch: exp st=%0d slot=%0d now=%0d prev=%0d chg=%0d",
                   exp_r.status, exp_r.rslot, exp_r.act_now, exp_r.act_prev,
                   exp_r.act_chg);
          $display("          got st=%0d slot=%0d now=%0d prev=%0d chg=%0d",
                   got.status, got.rslot, got.act_now, got.act_prev, got.act_chg);
        end
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        valid_i, ready_o, valid_o, ready_i;
  logic [2:0]  operation_i;
  logic [3:0]  slot_i;
  logic [15:0] pos_x_i, pos_y_i, size_w_i, size_h_i, owner_id_i;
  logic [1:0]  style_code_i;
  logic [1:0]  status_o;
  logic [3:0]  result_slot_o;
  logic [4:0]  active_now_o, active_before_o;
  logic        active_changed_o;

  zorder_scoreboard board;
  bit          calm;
  int unsigned cycles;

  window_zorder_table dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: sample results at the rising edge, stall on the falling edge.
  always @(posedge clk_i)
    if (rst_ni && valid_o && ready_i)
      board.check_result({status_o, result_slot_o, active_now_o, active_before_o,
                          active_changed_o});

  initial begin
    int unsigned stall;
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        ready_i = 1'b0;
        stall--;
      end else begin
        ready_i = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [3:0] sl, logic [15:0] px,
                           logic [15:0] py, logic [15:0] w, logic [15:0] h,
                           logic [15:0] own, logic [1:0] sty);
    if (!calm && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    valid_i = 1'b1; operation_i = op; slot_i = sl; pos_x_i = px; pos_y_i = py;
    size_w_i = w; size_h_i = h; owner_id_i = own; style_code_i = sty;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    board.note_item(op, sl, px, py, w, h, own, sty);
    @(negedge clk_i);
    valid_i = 1'b0;
  endtask

  task automatic drain();
    while (board.owed_q.size() != 0) @(negedge clk_i);
  endtask

  // Small geometry and few owners keep hits and owner matches frequent.
  task automatic random_item(bit noisy);
    logic [2:0]  op;
    logic [15:0] px, py, w, h, own;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      op = wzt_pkg::OpCreate;
    else if (sel < 50) op = wzt_pkg::OpDestroy;
    else if (sel < 58) op = wzt_pkg::OpDestOwn;
    else if (sel < 75) op = wzt_pkg::OpActive;
    else if (sel < 97) op = wzt_pkg::OpHit;
    else               op = 3'($urandom_range(OpIgnored, OpTopCode));
    if (noisy) begin
      px = 16'($urandom); py = 16'($urandom); w = 16'($urandom);
      h = 16'($urandom); own = 16'($urandom);
    end else begin
      px = 16'($signed($urandom_range(0, 200)) - 100);
      py = 16'($signed($urandom_range(0, 200)) - 100);
      w = 16'($urandom_range(0, 120)); h = 16'($urandom_range(0, 120));
      own = 16'($urandom_range(0, 5));
    end
    send_item(op, 4'($urandom_range(0, 15)), px, py, w, h, own,
              2'($urandom_range(0, 3)));
  endtask

  initial begin
    board = new();
    calm = 0; cycles = 0; rst_ni = 1'b0; valid_i = 1'b0;
    operation_i = '0; slot_i = '0; pos_x_i = '0; pos_y_i = '0; size_w_i = '0;
    size_h_i = '0; owner_id_i = '0; style_code_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, extremes, every operation, full table.
    send_item(wzt_pkg::OpHit, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpDestroy, 4'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpActive, 4'd15, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpDestOwn, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 2'd0);
    send_item(wzt_pkg::OpCreate, 4'd0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 2'd2);
    send_item(wzt_pkg::OpCreate, 4'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
              16'h0001, 2'd0);
    send_item(wzt_pkg::OpCreate, 4'd0, 16'hFFF0, 16'hFFF0, 16'h0020, 16'h0020,
              16'h0001, 2'd1);
    send_item(wzt_pkg::OpCreate, 4'd0, 16'h0000, 16'h0000, 16'h0010, 16'h0010,
              16'h0002, 2'd3);
    send_item(wzt_pkg::OpHit, 4'd0, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpHit, 4'd0, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpHit, 4'd0, 16'h0005, 16'h0005, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpActive, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpActive, 4'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpActive, 4'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(OpTopCode, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpDestroy, 4'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpDestOwn, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001, 2'd0);
    repeat (15) send_item(wzt_pkg::OpCreate, 4'd0, 16'h0, 16'h0, 16'h0004, 16'h0004,
                          16'h0009, 2'd0);
    send_item(wzt_pkg::OpCreate, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd0);
    send_item(wzt_pkg::OpDestOwn, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0009, 2'd0);

    // Hold off until the block is empty of work at least once.
    drain();

    for (int n = 0; n < 820; n++) begin
      if (n == 400) drain();
      if (n == 700) calm = 1;
      random_item($urandom_range(0, 9) == 0);
    end

    drain();
    repeat (2000) @(negedge clk_i);
    if (board.mism == 0 && board.owed_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wzt_pkg.sv
hdl/wzt_scan.sv
hdl/window_zorder_table.sv
tb/window_zorder_table_tb.sv
